@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ hdl/okvb_pkg.sv @@
// Shared types and constants of the ordered key/value extract buffer.
`default_nettype none

package okvb_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned VAL_W         = 32;

    typedef enum logic {
        MODE_INSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic occ;    // cell holds a live pair
        logic load;   // write the request pair into this cell
        logic shift;  // extract commits: cells at or after the hit take the neighbor
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/okvb_cell.sv @@
// One storage cell of the key/value chain: compare, priority pass-down, load and shift.
`default_nettype none

module okvb_cell
    import okvb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [KEY_W-1:0]  req_key,
    input  wire logic signed [VAL_W-1:0]  req_value,
    input  wire logic signed [KEY_W-1:0]  nb_key,
    input  wire logic signed [VAL_W-1:0]  nb_value,
    input  wire logic                     seen_in,
    input  wire logic        [VAL_W-1:0]  acc_in,
    output logic                          seen_out,
    output logic             [VAL_W-1:0]  acc_out,
    output logic signed      [KEY_W-1:0]  key_out,
    output logic signed      [VAL_W-1:0]  value_out
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    hit;
    logic                    take;

    assign hit      = ctrl.occ && (key_reg == req_key);
    assign take     = hit && !seen_in;
    assign seen_out = seen_in || hit;
    assign acc_out  = acc_in | (take ? VAL_W'(value_reg) : '0);
    assign key_out   = key_reg;
    assign value_out = value_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift && seen_out) begin
            key_reg   <= nb_key;
            value_reg <= nb_value;
        end else if (ctrl.load) begin
            key_reg   <= req_key;
            value_reg <= req_value;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ordered_key_value_extract_buffer.sv @@
// Top level of the ordered key/value extract buffer.
`default_nettype none
// Usage:
//   Requests enter on the s_ stream: s_tuser[0] selects insert (0) or extract (1),
//   s_tdata carries key and value. Each request yields exactly one response on the
//   m_ stream with the extracted value and a status code.
//   Insert appends the pair at the young end, or answers full at DEPTH pairs.
//   Extract searches from the oldest pair, returns the first matching value and
//   removes that pair; younger pairs move down one cell, keeping their order.
//   Flow: a request is captured into the request registers; then every cell compares
//   its key, the hit travels down the cell chain as a priority flag, the value
//   is gathered, the chain shifts and the response register loads. Only one
//   request is in flight at a time.
//   Stall: a pending response holds in the response register while m_tready is low;
//   a captured request waits for it, and s_tready stays low until that request commits.
//   Reset (aresetn low, synchronous) empties the buffer at once and drops any
//   pending response; no clearing pass runs.

module ordered_key_value_extract_buffer
    import okvb_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  wire logic [0:0]  s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [31:0] result_value, [33:32] status, [39:34] zero
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SRCH = 2'b10
    } fsm_t;

    fsm_t                    state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    mode_t                   req_mode_reg;
    logic signed [KEY_W-1:0] req_key_reg;
    logic signed [VAL_W-1:0] req_value_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [39:0]             m_tdata_reg, m_tdata_next;

    logic                    accept;
    logic                    commit;
    logic                    is_ext;
    logic                    full;
    logic                    empty;
    logic                    found;
    status_t                 status;
    logic [VAL_W-1:0]        result;

    // Chain wiring: index i feeds cell i, index DEPTH is the chain's far end.
    logic                    seen  [DEPTH+1];
    logic [VAL_W-1:0]        acc   [DEPTH+1];
    logic signed [KEY_W-1:0] ckey  [DEPTH];
    logic signed [VAL_W-1:0] cval  [DEPTH];
    logic signed [KEY_W-1:0] nbkey [DEPTH];
    logic signed [VAL_W-1:0] nbval [DEPTH];
    cell_ctrl_t              ctrl  [DEPTH];

    assign accept = s_tvalid && s_tready;
    assign commit = (state_reg == S_SRCH) && (!m_tvalid_reg || m_tready);
    assign is_ext = (req_mode_reg == MODE_EXTRACT);
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    assign seen[0] = 1'b0;
    assign acc[0]  = '0;
    assign found   = seen[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            // Cells at or above the count hold no live pair.
            assign ctrl[gi].occ   = (CW'(gi) < count_reg);
            assign ctrl[gi].load  = commit && !is_ext && !full && (CW'(gi) == count_reg);
            assign ctrl[gi].shift = commit && is_ext;

            if (gi == DEPTH - 1) begin : g_end
                assign nbkey[gi] = '0;
                assign nbval[gi] = '0;
            end else begin : g_mid
                assign nbkey[gi] = ckey[gi+1];
                assign nbval[gi] = cval[gi+1];
            end

            okvb_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl[gi]),
                .req_key   (req_key_reg),
                .req_value (req_value_reg),
                .nb_key    (nbkey[gi]),
                .nb_value  (nbval[gi]),
                .seen_in   (seen[gi]),
                .acc_in    (acc[gi]),
                .seen_out  (seen[gi+1]),
                .acc_out   (acc[gi+1]),
                .key_out   (ckey[gi]),
                .value_out (cval[gi])
            );
        end
    endgenerate

    // Response for the request under search.
    always_comb begin
        result = '0;
        if (!is_ext) begin
            status = full ? ST_FULL : ST_OK;
        end else if (empty) begin
            status = ST_EMPTY;
        end else if (found) begin
            status = ST_OK;
            result = acc[DEPTH];
        end else begin
            status = ST_NOT_FOUND;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (commit) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, 2'(status), result};
                    if (!is_ext && !full) begin
                        count_next = count_reg + CW'(1);
                    end else if (is_ext && found) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold request and response payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_mode_reg  <= mode_t'(s_tuser[0]);
            req_key_reg   <= s_tdata[31:0];
            req_value_reg <= s_tdata[63:32];
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ hdl/okvb_checker.sv @@
// Port-level checker for the ordered key/value extract buffer, with its bind.
`default_nettype none
`include "assert_macros.svh"

module okvb_port_checker
    import okvb_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    logic out_stall;
    logic in_take;
    logic not_ok;

    assign out_stall = m_tvalid && !m_tready;
    assign in_take   = s_tvalid && s_tready;
    assign not_ok    = (m_tdata[33:32] != ST_OK);

    // Reset drops any pending response.
    `ASSERT_NXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid)
    // A stalled response holds its payload.
    `ASSERT_NXT(a_stall_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata))
    // Only one request in flight: input closes right after a request is taken.
    `ASSERT_NXT(a_one_in_flight, aclk, aresetn, in_take, !s_tready)
    // Any status other than ok carries a zero value, and padding stays zero.
    `ASSERT_IMP(a_zero_fill, aclk, aresetn, m_tvalid,
                (!not_ok || m_tdata[31:0] == 32'd0) && m_tdata[39:34] == 6'd0)

endmodule

bind ordered_key_value_extract_buffer okvb_port_checker u_okvb_checker (.*);

`default_nettype wire

@@ bench/okvb_checker.sv @@
// Response checker for the ordered key/value extract buffer: tracks contents, compares responses.
module okvb_checker
    import okvb_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_tuser,   // [0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] result_value, [33:32] status, [39:34] zero
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        status_t          status;
    } response_t;

    // Shadow copy of the buffer, slot 0 oldest.
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    logic [VAL_W-1:0] shadow_vals [DEPTH];
    int unsigned      pairs_held;

    response_t due_responses [$];
    int        fail_tally;

    initial begin
        pairs_held  = 0;
        fail_tally  = 0;
        mismatches  = 0;
        outstanding = 0;
    end

    // Apply one request to the shadow buffer and return the response it must produce.
    function automatic response_t apply_request(mode_t mode, logic [KEY_W-1:0] key,
                                                logic [VAL_W-1:0] value);
        response_t resp;
        int        hit;
        resp.value = '0;
        hit        = -1;
        if (mode == MODE_INSERT) begin
            if (pairs_held >= DEPTH) begin
                resp.status = ST_FULL;
            end else begin
                shadow_keys[pairs_held] = key;
                shadow_vals[pairs_held] = value;
                pairs_held++;
                resp.status = ST_OK;
            end
        end else if (pairs_held == 0) begin
            resp.status = ST_EMPTY;
        end else begin
            for (int i = 0; i < pairs_held; i++)
                if (hit < 0 && shadow_keys[i] == key) hit = i;
            if (hit < 0) begin
                resp.status = ST_NOT_FOUND;
            end else begin
                resp.value  = shadow_vals[hit];
                resp.status = ST_OK;
                // close the gap, younger pairs keep their order
                for (int j = hit; j + 1 < pairs_held; j++) begin
                    shadow_keys[j] = shadow_keys[j + 1];
                    shadow_vals[j] = shadow_vals[j + 1];
                end
                pairs_held--;
            end
        end
        return resp;
    endfunction

    always @(posedge aclk) begin
        response_t want;
        if (!aresetn) begin
            pairs_held = 0;
            due_responses.delete();
        end else begin
            // compare first, so a response never pairs with the request of the same edge
            if (m_tvalid && m_tready) begin
                if (due_responses.size() == 0) begin
                    if (fail_tally < 10)
                        $display("%0t: response with none expected: value %h status %0d",
                                 $realtime, m_tdata[31:0], m_tdata[33:32]);
                    fail_tally++;
                end else begin
                    want = due_responses.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tdata[33:32] !== want.status ||
                        m_tdata[39:34] !== 6'd0) begin
                        if (fail_tally < 10)
                            $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d pad %h",
                                     $realtime, want.value, want.status, m_tdata[31:0],
                                     m_tdata[33:32], m_tdata[39:34]);
                        fail_tally++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_responses.push_back(apply_request(mode_t'(s_tuser[0]), s_tdata[31:0],
                                                      s_tdata[63:32]));
        end
        mismatches  <= fail_tally;
        outstanding <= due_responses.size();
    end

endmodule

@@ bench/testbench.sv @@
// Top of the bench: clock, reset, request and response traffic, final verdict.
module testbench;
    import okvb_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] key, [63:32] value
    logic [0:0]  s_tuser  = '0;   // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [31:0] result_value, [33:32] status, [39:34] zero

    int mismatches;
    int outstanding;

    // Set during phases that run back to back with no gaps on either side.
    bit steady = 1'b0;

    ordered_key_value_extract_buffer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    okvb_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Present one request after a random gap and hold it until the buffer takes it.
    // Called right after an edge; a zero gap keeps s_tvalid high across requests.
    task automatic send_request(mode_t mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {value, key};
        s_tuser[0] <= mode;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Response side: stall a random number of cycles per response, then accept.
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Hard stop in case the buffer hangs.
    initial begin
        #500000;
        $display("ordered_key_value_extract_buffer test failed");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0] pool [8];
        logic [KEY_W-1:0] key;
        int               insert_pct;
        bit               is_insert;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extract from an empty buffer.
        send_request(MODE_EXTRACT, 32'h0000_0000, 32'h1234_5678);
        // Key 0 with value 0 is an ordinary pair; add a duplicate key and the extremes.
        send_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0005);
        send_request(MODE_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_request(MODE_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        // Key that is not held.
        send_request(MODE_EXTRACT, 32'h0000_3039, 32'hffff_ffff);
        // Duplicate: the oldest pair goes first.
        send_request(MODE_EXTRACT, 32'h0000_0000, 32'h0000_0000);
        // Fill to the top; the last fill insert and the push after it both hit full.
        send_request(MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        for (int n = 0; n < 13; n++)
            send_request(MODE_INSERT, 32'h100 + n, $urandom());
        send_request(MODE_INSERT, 32'h5555_aaaa, 32'haaaa_5555);
        // Pull from near the old end of a full buffer so every younger pair shifts.
        send_request(MODE_EXTRACT, 32'h0000_0000, 32'h0000_0000);
        send_request(MODE_EXTRACT, 32'h8000_0000, 32'h0000_0000);
        send_request(MODE_EXTRACT, 32'h7fff_ffff, 32'h0000_0000);

        // Random phases: the insert share swings the fill level between empty and full,
        // and a small key pool per phase makes most extracts find a match.
        for (int ph = 0; ph < 16; ph++) begin
            steady = (ph % 4 == 3);
            case (ph % 3)
                0: insert_pct = 70;
                1: insert_pct = 50;
                default: insert_pct = 30;
            endcase
            for (int k = 0; k < 8; k++)
                pool[k] = $urandom();
            if (ph == 1) begin
                pool[0] = 32'h0000_0000;
                pool[1] = 32'hffff_ffff;
            end
            for (int n = 0; n < 103; n++) begin
                is_insert = ($urandom_range(0, 99) < insert_pct);
                key = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 7)] : $urandom();
                send_request(is_insert ? MODE_INSERT : MODE_EXTRACT, key, $urandom());
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Let the checker see the last request, drain, then allow a few quiet cycles.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("ordered_key_value_extract_buffer test passed");
        end else begin
            $display("ordered_key_value_extract_buffer test failed");
        end
        $finish;
    end

endmodule
